// ===== hdl/sirf_pkg.sv =====
// ----------------------------------------------------------------------------
// sirf_pkg
// Shared types and constants for the sequence identity redundancy filter.
// ----------------------------------------------------------------------------
package sirf_pkg;

  localparam int MAX_LEN     = 256;
  localparam int MAX_SEQS    = 256;
  localparam int STORE_DEPTH = 65536;

  localparam int LEN_W   = 9;   // lengths up to MAX_LEN + 1
  localparam int THR_W   = 17;
  localparam int CNT_W   = 16;
  localparam int TOTAL_W = 17;
  localparam int PROD_W  = THR_W + LEN_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [0:0] CFG_THRESHOLD = 1'd0;
  localparam logic [0:0] CFG_SKIP_LONG = 1'd1;

  localparam logic OP_LETTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    STAT_KEPT     = 3'd0,
    STAT_FILTERED = 3'd1,
    STAT_SKIPPED  = 3'd2,
    STAT_LONG_ERR = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_HALTED   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_RD,
    ST_LEN_CHK,
    ST_CMP,
    ST_CMP_DRAIN,
    ST_MUL,
    ST_CHK,
    ST_DECIDE,
    ST_COPY,
    ST_COPY_DRAIN,
    ST_OUT
  } state_t;

  // sequencer controls for the match scoring unit
  typedef struct packed {
    logic clear;   // restart match count
    logic pair;    // a letter pair is present
    logic mul;     // capture threshold times overlap
  } score_ctrl_t;

endpackage

// ===== hdl/sirf_score.sv =====
// ----------------------------------------------------------------------------
// sirf_score
// Match counter and identity threshold check, shared over all kept slots.
// ----------------------------------------------------------------------------
module sirf_score import sirf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  score_ctrl_t      ctrl,
  input  logic [7:0]       letter_a,
  input  logic [7:0]       letter_b,
  input  logic [THR_W-1:0] threshold,
  input  logic [LEN_W-1:0] overlap,
  output logic             similar
);

  logic [LEN_W-1:0]  hit_count;
  logic [PROD_W-1:0] product;

  // count equal letter pairs
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      hit_count <= '0;
    end else if (ctrl.pair && (letter_a == letter_b)) begin
      hit_count <= hit_count + LEN_W'(1);
    end
  end

  // threshold times overlap, registered before the compare
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      product <= PROD_W'(threshold) * PROD_W'(overlap);
    end
  end

  // hits * 65536 >= threshold * overlap
  assign similar = {{(PROD_W-LEN_W-16){1'b0}}, hit_count, 16'b0} >= product;

endmodule

// ===== hdl/sequence_identity_redundancy_filter.sv =====
// ----------------------------------------------------------------------------
// sequence_identity_redundancy_filter
// Greedy identity filter over a stream of sequence letters.
// ----------------------------------------------------------------------------
// Letters are taken one per cycle while the block is idle. On the letter that
// carries tlast the block stops taking input. A halted block or an over-long
// sequence goes straight to the output; a zero threshold or no kept sequence
// skips the walk. Otherwise the block walks the kept sequences in slot order
// through one shared match counter: each slot has a length read and check,
// min(len, slot length) compare steps, then drain, multiply and check; a slot
// of zero overlap skips the compare. A walk that ends at a matching slot goes
// straight to the output; otherwise a decide step follows, and a kept sequence
// is copied into the letter store at one letter a cycle. The result is then
// registered once the output is free. Clear items give no result. The store
// has a single read port, which sets the one-letter-per-cycle compare.
// ----------------------------------------------------------------------------
module sequence_identity_redundancy_filter import sirf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [THR_W-1:0]  cfg_data,
  // letter stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] letter
  input  logic              s_axis_tuser,   // [0] opcode
  input  logic              s_axis_tlast,
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [7:0] seq_index, [23:8] seq_offset, [32:24] seq_length, [41:33] kept_total,
  // [57:42] filtered_total_out, [73:58] skipped_total_out, [82:74] longest
  output logic [87:0]       m_axis_tdata,
  output logic [2:0]        m_axis_tuser    // [2:0] status
);

  state_t state, state_next;

  logic [THR_W-1:0]   threshold;
  logic               skip_long;

  logic [LEN_W-1:0]   letter_count;
  logic [LEN_W-1:0]   kept_count;
  logic [CNT_W-1:0]   drop_total;
  logic [CNT_W-1:0]   skip_total;
  logic [TOTAL_W-1:0] total_length;
  logic [LEN_W-1:0]   longest_length;
  logic               halted;

  logic [LEN_W-1:0]   seq_len;
  logic [LEN_W-1:0]   slot;
  logic [TOTAL_W-1:0] base;
  logic [LEN_W-1:0]   other_len;
  logic [LEN_W-1:0]   overlap;
  logic [LEN_W-1:0]   idx;

  status_t            res_status;
  logic [7:0]         res_index;
  logic [15:0]        res_offset;
  logic [LEN_W-1:0]   res_len;

  logic [7:0] current_letters [MAX_LEN];
  logic [7:0] stored_letters  [STORE_DEPTH];
  logic [LEN_W-1:0] stored_lengths [MAX_SEQS];

  logic [7:0]       cur_q;
  logic [7:0]       store_q;
  logic [LEN_W-1:0] len_q;
  logic             pair_valid;
  logic             copy_valid;
  logic [15:0]      copy_addr;
  logic [15:0]      store_raddr;

  logic             in_xfer;
  logic             out_free;
  logic             similar;
  logic [LEN_W-1:0] len_closed;
  logic [LEN_W-1:0] min_len;
  logic             no_room;
  score_ctrl_t      score_ctrl;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign len_closed = (letter_count <= LEN_W'(MAX_LEN)) ? letter_count + LEN_W'(1)
                                                        : letter_count;
  assign min_len    = (seq_len < len_q) ? seq_len : len_q;
  assign no_room    = (kept_count >= LEN_W'(MAX_SEQS)) ||
                      ((total_length + TOTAL_W'(seq_len)) > TOTAL_W'(STORE_DEPTH));
  assign store_raddr = base[15:0] + {8'b0, idx[7:0]};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      skip_long <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data;
        CFG_SKIP_LONG: skip_long <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && s_axis_tuser == OP_LETTER && s_axis_tlast) begin
          if (halted || len_closed > LEN_W'(MAX_LEN)) begin
            state_next = ST_OUT;
          end else if (threshold != '0 && kept_count != '0) begin
            state_next = ST_LEN_RD;
          end else begin
            state_next = ST_DECIDE;
          end
        end
      end
      ST_LEN_RD:  state_next = ST_LEN_CHK;
      ST_LEN_CHK: begin
        if (min_len == '0) begin
          state_next = (slot + LEN_W'(1) == kept_count) ? ST_DECIDE : ST_LEN_RD;
        end else begin
          state_next = ST_CMP;
        end
      end
      ST_CMP:       state_next = (idx == overlap - LEN_W'(1)) ? ST_CMP_DRAIN : ST_CMP;
      ST_CMP_DRAIN: state_next = ST_MUL;
      ST_MUL:       state_next = ST_CHK;
      ST_CHK: begin
        if (similar) begin
          state_next = ST_OUT;
        end else begin
          state_next = (slot + LEN_W'(1) == kept_count) ? ST_DECIDE : ST_LEN_RD;
        end
      end
      ST_DECIDE:     state_next = no_room ? ST_OUT : ST_COPY;
      ST_COPY:       state_next = (idx == seq_len - LEN_W'(1)) ? ST_COPY_DRAIN : ST_COPY;
      ST_COPY_DRAIN: state_next = ST_OUT;
      ST_OUT:        state_next = out_free ? ST_IDLE : ST_OUT;
      default:       state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready    = (state == ST_IDLE);
    score_ctrl.clear = (state == ST_LEN_CHK);
    score_ctrl.pair  = pair_valid;
    score_ctrl.mul   = (state == ST_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memories: registered reads every cycle
  always_ff @(posedge clk) begin
    cur_q   <= current_letters[idx[7:0]];
    store_q <= stored_letters[store_raddr];
    len_q   <= stored_lengths[slot[7:0]];
    if (state == ST_IDLE && in_xfer && s_axis_tuser == OP_LETTER && !halted &&
        letter_count < LEN_W'(MAX_LEN)) begin
      current_letters[letter_count[7:0]] <= s_axis_tdata;
    end
    if (copy_valid) begin
      stored_letters[copy_addr] <= cur_q;
    end
    if (state == ST_COPY_DRAIN) begin
      stored_lengths[kept_count[7:0]] <= seq_len;
    end
  end

  // read pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      copy_valid <= 1'b0;
    end else begin
      pair_valid <= (state == ST_CMP);
      copy_valid <= (state == ST_COPY);
    end
    copy_addr <= total_length[15:0] + {8'b0, idx[7:0]};
  end

  // sequencer datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      letter_count   <= '0;
      kept_count     <= '0;
      drop_total     <= '0;
      skip_total     <= '0;
      total_length   <= '0;
      longest_length <= '0;
      halted         <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser == OP_CLEAR) begin
              letter_count   <= '0;
              kept_count     <= '0;
              drop_total     <= '0;
              skip_total     <= '0;
              total_length   <= '0;
              longest_length <= '0;
              halted         <= 1'b0;
            end else if (!halted) begin
              letter_count <= s_axis_tlast ? '0 : len_closed;
              if (s_axis_tlast && len_closed > LEN_W'(MAX_LEN)) begin
                if (skip_long) begin
                  if (skip_total != CNT_MAX) begin
                    skip_total <= skip_total + CNT_W'(1);
                  end
                end else begin
                  halted <= 1'b1;
                end
              end
            end
          end
        end
        ST_CHK: begin
          if (similar && drop_total != CNT_MAX) begin
            drop_total <= drop_total + CNT_W'(1);
          end
        end
        ST_COPY_DRAIN: begin
          kept_count   <= kept_count + LEN_W'(1);
          total_length <= total_length + TOTAL_W'(seq_len);
          if (seq_len > longest_length) begin
            longest_length <= seq_len;
          end
        end
        default: ;
      endcase
    end
  end

  // walk registers and pending result
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        seq_len    <= len_closed;
        slot       <= '0;
        base       <= '0;
        idx        <= '0;
        res_index  <= '0;
        res_offset <= '0;
        res_len    <= len_closed;
        if (halted) begin
          res_status <= STAT_HALTED;
          res_len    <= '0;
        end else if (skip_long) begin
          res_status <= STAT_SKIPPED;
        end else begin
          res_status <= STAT_LONG_ERR;
        end
      end
      ST_LEN_CHK: begin
        other_len <= len_q;
        overlap   <= min_len;
        idx       <= '0;
        if (min_len == '0) begin
          base <= base + TOTAL_W'(len_q);
          slot <= slot + LEN_W'(1);
        end
      end
      ST_CMP: idx <= idx + LEN_W'(1);
      ST_CHK: begin
        if (similar) begin
          res_status <= STAT_FILTERED;
          res_index  <= slot[7:0];
        end else begin
          base <= base + TOTAL_W'(other_len);
          slot <= slot + LEN_W'(1);
        end
      end
      ST_DECIDE: begin
        idx <= '0;
        if (no_room) begin
          res_status <= STAT_FULL;
        end
      end
      ST_COPY: idx <= idx + LEN_W'(1);
      ST_COPY_DRAIN: begin
        res_status <= STAT_KEPT;
        res_index  <= kept_count[7:0];
        res_offset <= total_length[15:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (state == ST_OUT && out_free) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {5'b0, longest_length, skip_total, drop_total,
                       kept_count, res_len, res_offset, res_index};
    end
  end

  sirf_score u_score (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (score_ctrl),
    .letter_a  (cur_q),
    .letter_b  (store_q),
    .threshold (threshold),
    .overlap   (overlap),
    .similar   (similar)
  );

endmodule
